>>> src/trn_pkg.sv
`default_nettype none
package trn_pkg;

  localparam int COORD_WIDTH = 32;
  // coordinates wider than the 32-bit field read as nonnegative 33-bit values
  localparam int CRD_W  = (COORD_WIDTH > 32) ? 33 : COORD_WIDTH;
  localparam int DIFF_W = CRD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int LO_W   = (MAG_W + 1) / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int S_W    = SQ_W + 2;

  localparam int NRM_W    = 32;
  localparam int NRM_FRAC = 30;
  localparam int QBITS    = 31;
  localparam int R_W      = S_W + 2 * (QBITS + 1) + 3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic REG_NORMAL_LEN = 1'b0;
  localparam logic REG_CROSS_LEN  = 1'b1;
  localparam logic [31:0] NORMAL_LEN_RESET = 32'd1074;
  localparam logic [31:0] CROSS_LEN_RESET  = 32'd18446744;

  typedef struct packed {
    logic [31:0] normal_len_threshold;
    logic [31:0] cross_len_threshold;
  } trn_cfg_t;

  typedef struct packed {
    logic                        recompute;
    logic [2:0][NRM_W-1:0]       normal;
    logic [2:0]                  neg;
    logic [2:0][SQ_W-1:0]        sq;
    logic [S_W-1:0]              s;
  } trn_item_t;

  function automatic logic signed [CRD_W-1:0] coord(input logic [31:0] f);
    logic [47:0] ext;
    ext = {16'b0, f};
    return ext[CRD_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/triangle_normal_repair_unit.sv
// triangle facet normal repair
// input channel (in_valid / in_stall): one triangle per item, stored normal in
// signed Q2.30 and three vertices in signed Q16.16. output channel (out_valid /
// out_stall): the normal to keep, Q2.30, and a flag set when it was rebuilt
// from the normalized cross product (v1-v0) x (v2-v0).
// an item is taken at an edge with valid high and stall low on its channel.
// throughput: one item per cycle while neither channel stalls. an accepted item
// passes the 7-stage front (differences, multipliers, squared lengths,
// threshold tests), one queue slot, and the back: a loading stage, then 31
// stages that produce one quotient bit per stage for all three components,
// plus its output register, before out_valid rises.
// a 4-entry queue sits between front and back; when out_stall is held the back
// freezes, the queue fills, and in_stall rises once the front's last stage
// holds an item that cannot enter the queue. in_stall comes from registers only.
// apb port: normal_len_threshold at 0x0, cross_len_threshold at 0x4; the user
// writes them only while the block is idle, a rule the block does not enforce.
// reset (rst, synchronous) empties the pipelines and queue and restores the
// threshold registers to their defaults.
`default_nettype none
module triangle_normal_repair_unit
  import trn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] normal_in_x,
  input  logic [31:0] normal_in_y,
  input  logic [31:0] normal_in_z,
  input  logic [31:0] vert0_x,
  input  logic [31:0] vert0_y,
  input  logic [31:0] vert0_z,
  input  logic [31:0] vert1_x,
  input  logic [31:0] vert1_y,
  input  logic [31:0] vert1_z,
  input  logic [31:0] vert2_x,
  input  logic [31:0] vert2_y,
  input  logic [31:0] vert2_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] normal_out_x,
  output logic [31:0] normal_out_y,
  output logic [31:0] normal_out_z,
  output logic        recomputed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  trn_cfg_t              cfg;
  trn_item_t             push_item, pop_item;
  logic                  push, pop, q_full, q_empty;
  logic [2:0][NRM_W-1:0] nout;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_len_threshold <= NORMAL_LEN_RESET;
      cfg.cross_len_threshold  <= CROSS_LEN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_NORMAL_LEN: cfg.normal_len_threshold <= pwdata;
        REG_CROSS_LEN:  cfg.cross_len_threshold  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NORMAL_LEN: prdata = cfg.normal_len_threshold;
      REG_CROSS_LEN:  prdata = cfg.cross_len_threshold;
      default:        prdata = '0;
    endcase
  end

  trn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .nin       ({normal_in_z, normal_in_y, normal_in_x}),
    .vt0       ({vert0_z, vert0_y, vert0_x}),
    .vt1       ({vert1_z, vert1_y, vert1_x}),
    .vt2       ({vert2_z, vert2_y, vert2_x}),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  trn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  trn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .normal_out (nout),
    .recomputed (recomputed)
  );

  assign normal_out_x = nout[0];
  assign normal_out_y = nout[1];
  assign normal_out_z = nout[2];

endmodule
`default_nettype wire

>>> src/trn_front.sv
`default_nettype none
module trn_front
  import trn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0][NRM_W-1:0] nin,
  input  logic [2:0][31:0]      vt0,
  input  logic [2:0][31:0]      vt1,
  input  logic [2:0][31:0]      vt2,
  input  trn_cfg_t              cfg,
  input  logic                  q_full,
  output logic                  push,
  output trn_item_t             push_item
);

  logic [6:0] v;
  logic       adv;

  logic [2:0][NRM_W-1:0] nrm [0:6];
  logic signed [DIFF_W-1:0] d1 [3];
  logic signed [DIFF_W-1:0] d2 [3];
  logic signed [DIFF_W-1:0] d1_in [3];
  logic signed [DIFF_W-1:0] d2_in [3];
  logic [63:0] nsq [3];
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic [2:5] try_s;
  logic [2:0] neg [2:6];
  logic [MAG_W-1:0] mag [3];
  logic [2*LO_W-1:0] pp_ll [3];
  logic [LO_W+HI_W-1:0] pp_lh [3];
  logic [2*HI_W-1:0] pp_hh [3];
  logic [2:0][SQ_W-1:0] sq [4:6];
  logic [S_W-1:0] s5, s6;
  logic rec6;

  logic [63:0] len2;
  logic signed [CROSS_W-1:0] cr [3];
  logic signed [CROSS_W-1:0] cr_abs [3];

  assign adv      = !(v[6] && q_full);
  assign in_stall = v[6] && q_full;
  assign push     = v[6] && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_in[i] = DIFF_W'(coord(vt1[i])) - DIFF_W'(coord(vt0[i]));
      d2_in[i] = DIFF_W'(coord(vt2[i])) - DIFF_W'(coord(vt0[i]));
    end
    len2 = nsq[0] + nsq[1] + nsq[2];
    for (int i = 0; i < 3; i++) begin
      cr[i]     = CROSS_W'(pa[i]) - CROSS_W'(pb[i]);
      cr_abs[i] = cr[i][CROSS_W-1] ? -cr[i] : cr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm[0] <= nin;
      for (int st = 1; st < 7; st++) nrm[st] <= nrm[st-1];
      for (int i = 0; i < 3; i++) begin
        d1[i]  <= d1_in[i];
        d2[i]  <= d2_in[i];
        nsq[i] <= 64'($signed(nrm[0][i])) * 64'($signed(nrm[0][i]));
        pa[i]  <= PROD_W'(d1[(i+1)%3]) * PROD_W'(d2[(i+2)%3]);
        pb[i]  <= PROD_W'(d1[(i+2)%3]) * PROD_W'(d2[(i+1)%3]);
        neg[2][i] <= cr[i][CROSS_W-1];
        mag[i]    <= cr_abs[i][MAG_W-1:0];
        pp_ll[i]  <= (2*LO_W)'(mag[i][LO_W-1:0]) * (2*LO_W)'(mag[i][LO_W-1:0]);
        pp_lh[i]  <= (LO_W+HI_W)'(mag[i][LO_W-1:0]) * (LO_W+HI_W)'(mag[i][MAG_W-1:LO_W]);
        pp_hh[i]  <= (2*HI_W)'(mag[i][MAG_W-1:LO_W]) * (2*HI_W)'(mag[i][MAG_W-1:LO_W]);
        sq[4][i]  <= (SQ_W'(pp_hh[i]) << (2*LO_W)) + (SQ_W'(pp_lh[i]) << (LO_W+1))
                     + SQ_W'(pp_ll[i]);
      end
      // exact test: |n|^2 below threshold * 2^-30
      try_s[2] <= len2 < 64'({cfg.normal_len_threshold, NRM_FRAC'(0)});
      for (int st = 3; st <= 5; st++) try_s[st] <= try_s[st-1];
      for (int st = 3; st <= 6; st++) neg[st] <= neg[st-1];
      sq[5] <= sq[4];
      sq[6] <= sq[5];
      s5 <= S_W'(sq[4][0]) + S_W'(sq[4][1]) + S_W'(sq[4][2]);
      s6 <= s5;
      rec6 <= try_s[5] && (s5 > S_W'(cfg.cross_len_threshold));
    end
  end

  always_comb begin
    push_item.recompute = rec6;
    push_item.normal    = nrm[6];
    push_item.neg       = neg[6];
    push_item.sq        = sq[6];
    push_item.s         = s6;
  end

endmodule
`default_nettype wire

>>> src/trn_queue.sv
`default_nettype none
module trn_queue
  import trn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  trn_item_t push_item,
  input  logic      pop,
  output trn_item_t pop_item,
  output logic      full,
  output logic      empty
);

  trn_item_t          entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

>>> src/trn_back.sv
`default_nettype none
module trn_back
  import trn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  trn_item_t             q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0][NRM_W-1:0] normal_out,
  output logic                  recomputed
);

  logic [QBITS:0] vb;
  logic           vo;
  logic           b_adv;

  logic signed [R_W-1:0] r [0:QBITS][3];
  logic signed [R_W-1:0] p [0:QBITS][3];
  logic [QBITS-1:0]      qv [0:QBITS][3];
  logic [S_W-1:0]        s_st [0:QBITS-1];
  logic                  rec_st [0:QBITS];
  logic [2:0][NRM_W-1:0] nrm_st [0:QBITS];
  logic [2:0]            neg_st [0:QBITS];

  logic signed [R_W-1:0] cand [1:QBITS][3];
  logic [2:0]            acc [1:QBITS];
  logic [NRM_W-1:0]      res [3];

  assign b_adv     = !(vo && out_stall);
  assign pop       = b_adv && !q_empty;
  assign out_valid = vo;

  // per bit b: try u + 2^(b+1), r tracks rhs - u^2*s and p tracks u*s
  always_comb begin
    for (int st = 1; st <= QBITS; st++) begin
      for (int i = 0; i < 3; i++) begin
        cand[st][i] = r[st-1][i] - (p[st-1][i] <<< (QBITS - st + 2))
                      - ($signed(R_W'(s_st[st-1])) <<< (2*(QBITS - st) + 2));
        acc[st][i]  = !cand[st][i][R_W-1];
      end
    end
    for (int i = 0; i < 3; i++) begin
      res[i] = neg_st[QBITS][i] ? (NRM_W'(0) - NRM_W'(qv[QBITS][i]))
                                : NRM_W'(qv[QBITS][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
      vo <= 1'b0;
    end else if (b_adv) begin
      vb <= {vb[QBITS-1:0], pop};
      vo <= vb[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      rec_st[0] <= q_item.recompute;
      nrm_st[0] <= q_item.normal;
      neg_st[0] <= q_item.neg;
      s_st[0]   <= q_item.s;
      for (int i = 0; i < 3; i++) begin
        r[0][i]  <= $signed(R_W'(q_item.sq[i]) << (2*QBITS)) - $signed(R_W'(q_item.s));
        p[0][i]  <= -$signed(R_W'(q_item.s));
        qv[0][i] <= '0;
      end
      for (int st = 1; st < QBITS; st++) s_st[st] <= s_st[st-1];
      for (int st = 1; st <= QBITS; st++) begin
        rec_st[st] <= rec_st[st-1];
        nrm_st[st] <= nrm_st[st-1];
        neg_st[st] <= neg_st[st-1];
        for (int i = 0; i < 3; i++) begin
          if (acc[st][i]) begin
            r[st][i]  <= cand[st][i];
            p[st][i]  <= p[st-1][i]
                         + ($signed(R_W'(s_st[st-1])) <<< (QBITS - st + 1));
            qv[st][i] <= qv[st-1][i] | (QBITS'(1) << (QBITS - st));
          end else begin
            r[st][i]  <= r[st-1][i];
            p[st][i]  <= p[st-1][i];
            qv[st][i] <= qv[st-1][i];
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        normal_out[i] <= rec_st[QBITS] ? res[i] : nrm_st[QBITS][i];
      end
      recomputed <= rec_st[QBITS];
    end
  end

endmodule
`default_nettype wire

>>> src/trn_chk.sv
`default_nettype none
module trn_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] normal_out_x,
  input logic [31:0] normal_out_y,
  input logic [31:0] normal_out_z,
  input logic        recomputed
);

  a_out_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_in_reset: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("in_stall high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(normal_out_x)
      && $stable(normal_out_y) && $stable(normal_out_z) && $stable(recomputed))
    else $error("stalled result changed");

  // a rebuilt normal is a unit vector, so no component exceeds 1.0
  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && recomputed |->
      ($signed(normal_out_x) <= 32'sh40000000) && ($signed(normal_out_x) >= -32'sh40000000)
      && ($signed(normal_out_y) <= 32'sh40000000) && ($signed(normal_out_y) >= -32'sh40000000)
      && ($signed(normal_out_z) <= 32'sh40000000) && ($signed(normal_out_z) >= -32'sh40000000))
    else $error("rebuilt normal component out of range");

endmodule

bind triangle_normal_repair_unit trn_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .normal_out_x (normal_out_x),
  .normal_out_y (normal_out_y),
  .normal_out_z (normal_out_z),
  .recomputed   (recomputed)
);
`default_nettype wire

>>> tb/triangle_normal_repair_checker.sv
`timescale 1ns / 1ps
module triangle_normal_repair_checker
  import trn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0][31:0]  normal_in,
  input  logic [8:0][31:0]  verts,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0][31:0]  normal_out,
  input  logic              recomputed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending,
  output int                rebuilt
);

  typedef struct packed {
    logic [2:0][31:0] n;
    logic             rec;
  } facet_normal_t;

  facet_normal_t expected_normals[$];
  logic [31:0] normal_len_thr;
  logic [31:0] cross_len_thr;

  function automatic facet_normal_t repair_normal(input logic [2:0][31:0] nrm,
                                                  input logic [8:0][31:0] vtx,
                                                  input logic [31:0] nthr,
                                                  input logic [31:0] cthr);
    facet_normal_t res;
    logic signed [63:0] sn;
    logic [63:0] len2, mlen;
    logic signed [33:0] d1 [3];
    logic signed [33:0] d2 [3];
    logic signed [69:0] c [3];
    logic [69:0] mag;
    logic [139:0] sq [3];
    logic [139:0] s;
    logic [255:0] lhs, rhs;
    logic [31:0] q, t;
    logic [63:0] k;
    int j, l;
    res.n = nrm;
    res.rec = 1'b0;
    len2 = '0;
    for (int i = 0; i < 3; i++) begin
      sn = $signed(nrm[i]);
      mlen = (sn < 0) ? -sn : sn;
      len2 += mlen * mlen;
      d1[i] = $signed(vtx[3+i]) - $signed(vtx[i]);
      d2[i] = $signed(vtx[6+i]) - $signed(vtx[i]);
    end
    if (len2 >= ({32'b0, nthr} << 30)) return res;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      l = (i + 2) % 3;
      c[i] = d1[j] * d2[l] - d1[l] * d2[j];
      mag = (c[i] < 0) ? -c[i] : c[i];
      sq[i] = 140'(mag) * 140'(mag);
      s += sq[i];
    end
    if (s <= {108'b0, cthr}) return res;
    for (int i = 0; i < 3; i++) begin
      q = '0;
      rhs = 256'(sq[i]) << 62;
      // bisect for round(|c_i| * 2^30 / |c|), ties away from zero
      for (int b = 30; b >= 0; b--) begin
        t = q | (32'd1 << b);
        k = 2 * {32'b0, t} - 1;
        lhs = 256'(k) * 256'(k) * 256'(s);
        if (lhs <= rhs) q = t;
      end
      if (q > 32'h7fffffff) q = 32'h7fffffff;
      res.n[i] = (c[i] < 0) ? -q : q;
    end
    res.rec = 1'b1;
    return res;
  endfunction

  assign pending = expected_normals.size();

  always @(posedge clk) begin
    facet_normal_t want;
    if (rst) begin
      normal_len_thr = NORMAL_LEN_RESET;
      cross_len_thr = CROSS_LEN_RESET;
      expected_normals.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_CROSS_LEN) cross_len_thr = pwdata;
        else normal_len_thr = pwdata;
      end
      if (in_valid && !in_stall)
        expected_normals.insert(expected_normals.size(),
                                repair_normal(normal_in, verts, normal_len_thr,
                                              cross_len_thr));
      if (out_valid && !out_stall) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected item: n=%h %h %h rec=%b", $time, normal_out[0],
                   normal_out[1], normal_out[2], recomputed);
          errors++;
        end else begin
          want = expected_normals.pop_front();
          if (want.rec) rebuilt++;
          for (int i = 0; i < 3; i++)
            if (normal_out[i] !== want.n[i]) begin
              $display("%0t: normal[%0d] expected %h actual %h", $time, i, want.n[i],
                       normal_out[i]);
              errors++;
            end
          if (recomputed !== want.rec) begin
            $display("%0t: recomputed expected %b actual %b", $time, want.rec,
                     recomputed);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    rebuilt = 0;
  end

endmodule

>>> tb/triangle_normal_repair_unit_test.sv
`timescale 1ns / 1ps
module triangle_normal_repair_unit_test;
  import trn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 290;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [2:0][31:0] normal_in = '0;
  logic [8:0][31:0] verts = '0;
  logic in_stall, out_valid, recomputed, pready;
  logic [31:0] normal_out_x, normal_out_y, normal_out_z, prdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  int errors, pending, rebuilt;
  int tx_idle_pct, rx_idle_pct;
  int cycles = 0;
  int sent = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  triangle_normal_repair_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .normal_in_x(normal_in[0]), .normal_in_y(normal_in[1]), .normal_in_z(normal_in[2]),
    .vert0_x(verts[0]), .vert0_y(verts[1]), .vert0_z(verts[2]),
    .vert1_x(verts[3]), .vert1_y(verts[4]), .vert1_z(verts[5]),
    .vert2_x(verts[6]), .vert2_y(verts[7]), .vert2_z(verts[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_out_x(normal_out_x), .normal_out_y(normal_out_y),
    .normal_out_z(normal_out_z), .recomputed(recomputed),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  triangle_normal_repair_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .normal_in(normal_in), .verts(verts), .out_valid(out_valid),
    .out_stall(out_stall),
    .normal_out({normal_out_z, normal_out_y, normal_out_x}),
    .recomputed(recomputed), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .rebuilt(rebuilt)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_normal_repair_unit_test: done, errors");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) hold_left--;
    else if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_triangle(input logic [2:0][31:0] n, input logic [8:0][31:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    normal_in <= n;
    verts <= v;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] small_signed(input int span);
    return $urandom_range(1) ? -$urandom_range(span) : $urandom_range(span);
  endfunction

  task automatic random_triangle();
    logic [2:0][31:0] n;
    logic [8:0][31:0] v;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++)
      n[i] = (kind < 6) ? small_signed(kind < 2 ? 0 : 40000) : $urandom;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      v[i] = $urandom;
      if (kind < 4) begin
        v[3+i] = $urandom;
        v[6+i] = $urandom;
      end else begin
        v[3+i] = v[i] + small_signed(kind < 6 ? 8 : 1 << 20);
        v[6+i] = v[i] + small_signed(kind < 6 ? 8 : 1 << 20);
      end
    end
    // degenerate: repeated vertex
    if (kind == 9) v[8:6] = v[5:3];
    send_triangle(n, v);
  endtask

  task automatic directed_triangles();
    logic [31:0] top, bot;
    top = 32'h7fffffff;
    bot = 32'h80000000;
    send_triangle('0, '0);
    send_triangle('0, {96'b0, 32'h0, 32'h10000, 32'h0, 64'b0, 32'h10000, 96'b0});
    send_triangle({32'h0, 32'h0, 32'h40000000}, {96'b0, 96'h1, 96'h1 << 64});
    send_triangle({3{bot}}, {{3{top}}, {3{bot}}, {3{top}}});
    send_triangle('0, {{3{top}}, {3{bot}}, {3{top}}});
    send_triangle('0, {top, bot, top, bot, top, bot, bot, top, bot});
    send_triangle('0, {bot, top, 32'h0, top, 32'h0, bot, 32'h0, bot, top});
    send_triangle({32'h1, 32'hffffffff, 32'h0}, {32'h5, 32'h3, 32'h1, 96'b0, 96'h0});
    send_triangle({3{top}}, {32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 96'b0});
    send_triangle('0, {32'h1, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 96'b0});
    send_triangle('0, {32'h0, 32'h3, 32'h0, 32'h4, 32'h0, 32'h0, 96'b0});
    send_triangle('0, {32'h10000, 32'h20000, 32'h30000, 96'h0, 96'h0});
    send_triangle({32'h0, 32'h0, 32'h7ff}, {32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0,
                                            96'b0});
    send_triangle({32'h0, 32'hfffff800, 32'h0}, {32'h2, 32'h0, 32'h0, 32'h0, 32'h2,
                                                 32'h0, 96'b0});
  endtask

  initial begin
    logic [1:0][31:0] settings [6];
    settings[0] = {32'd18446744, 32'd1074};
    settings[1] = {32'h0, 32'hffffffff};
    settings[2] = {32'hffffffff, 32'hffffffff};
    settings[3] = {32'hffffffff, 32'h0};
    settings[4] = {$urandom_range(1 << 30), $urandom_range(1 << 20)};
    settings[5] = {32'h1, 32'h1};
    tx_idle_pct = 9;
    rx_idle_pct = 51;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_triangles();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_NORMAL_LEN, settings[p][0]);
      write_reg(REG_CROSS_LEN, settings[p][1]);
      if (p == 2) begin
        tx_idle_pct = 51;
        rx_idle_pct = 9;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 1 || p == 5) hold_req = 1'b1;
      if (p == 0) directed_triangles();
      for (int i = 0; i < PHASE_ITEMS; i++) random_triangle();
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    $display("sent %0d triangles over 6 threshold settings, %0d normals rebuilt",
             sent, rebuilt);
    if (errors == 0) begin
      $display("triangle_normal_repair_unit_test: done, clean");
    end else begin
      $display("triangle_normal_repair_unit_test: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
src/trn_pkg.sv
src/trn_front.sv
src/trn_queue.sv
src/trn_back.sv
src/triangle_normal_repair_unit.sv
src/trn_chk.sv
tb/triangle_normal_repair_checker.sv
tb/triangle_normal_repair_unit_test.sv
